>>> rtl/ngmr_pkg.sv
// Package for the base-2 Niederreiter generating-matrix row generator.
// Holds sizes, limits, the controller state type and the unit command structs.
// No dependencies.
package ngmr_pkg;

    localparam int MAX_SIZE    = 30;
    localparam int POWER_LIMIT = 63;

    localparam int POLY_W = 64;
    localparam int LOW_W  = 63;
    localparam int DEG_W  = 6;
    localparam int SIZE_W = 5;
    localparam int ROW_W  = 30;
    localparam int STEP_W = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SERIES,
        ST_EMIT
    } ngmr_state_t;

    typedef struct packed {
        logic             start;
        logic [DEG_W-1:0] count;
    } ngmr_mul_cmd_t;

    typedef struct packed {
        logic done;
    } ngmr_mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DEG_W-1:0]  k;
        logic [SIZE_W-1:0] m;
        logic [DEG_W-1:0]  d;
    } ngmr_ser_cmd_t;

    typedef struct packed {
        logic             done;
        logic [ROW_W-1:0] bits;
    } ngmr_ser_rsp_t;

endpackage

>>> rtl/ngmr_if.sv
// Valid/ready channel interfaces: polynomial input, matrix row output, size write.
// Depends on ngmr_pkg.
interface ngmr_in_if;
    logic                       valid;
    logic                       ready;
    logic [ngmr_pkg::LOW_W-1:0] poly_low_bits;
    logic [ngmr_pkg::DEG_W-1:0] degree;

    modport source (output valid, output poly_low_bits, output degree, input ready);
    modport sink   (input valid, input poly_low_bits, input degree, output ready);
endinterface

interface ngmr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ngmr_pkg::SIZE_W-1:0] row_index;
    logic [ngmr_pkg::ROW_W-1:0]  row_bits;
    logic                        last_row;
    logic                        degree_error;

    modport source (output valid, output row_index, output row_bits, output last_row,
                    output degree_error, input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_row,
                    input degree_error, output ready);
endinterface

interface ngmr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ngmr_pkg::SIZE_W-1:0] matrix_size;

    modport source (output valid, output matrix_size, input ready);
    modport sink   (input valid, input matrix_size, output ready);
endinterface

>>> rtl/niederreiter_gf2_matrix_rows.sv
// Sequence: after a polynomial beat the check steps find the top power degree; each row then
// runs the series unit, after a multiply where the row enters a new power, and is emitted.
// Flow: one polynomial at a time, limited by the serial divider and multiplier;
// the next polynomial is taken once the last row sits in the output register.
// Reset: matrix_size returns to 30, controller idle, no row pending.
// Depends on ngmr_pkg, ngmr_if, ngmr_clmul and ngmr_series.
module niederreiter_gf2_matrix_rows
(
    input  logic        clk,
    input  logic        rst_n,
    ngmr_cfg_if.sink    cfg,
    ngmr_in_if.sink     poly,
    ngmr_out_if.source  rows
);

    ngmr_pkg::ngmr_state_t state_reg, state_next;

    logic [ngmr_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [ngmr_pkg::SIZE_W-1:0] m_reg, m_next;
    logic [ngmr_pkg::DEG_W-1:0]  e_reg, e_next;
    logic [ngmr_pkg::POLY_W-1:0] p_reg, p_next;
    logic [ngmr_pkg::POLY_W-1:0] pw_reg, pw_next;
    logic [ngmr_pkg::DEG_W-1:0]  d_reg, d_next;
    logic [ngmr_pkg::DEG_W-1:0]  k_reg, k_next;
    logic [ngmr_pkg::SIZE_W-1:0] row_reg, row_next;
    logic [ngmr_pkg::STEP_W-1:0] chk_reg, chk_next;
    logic                        err_reg, err_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ngmr_pkg::SIZE_W-1:0] out_index_reg, out_index_next;
    logic [ngmr_pkg::ROW_W-1:0]  out_bits_reg, out_bits_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_err_reg, out_err_next;

    ngmr_pkg::ngmr_mul_cmd_t     mul_cmd;
    ngmr_pkg::ngmr_mul_rsp_t     mul_rsp;
    logic [ngmr_pkg::POLY_W-1:0] product;
    ngmr_pkg::ngmr_ser_cmd_t     ser_cmd;
    ngmr_pkg::ngmr_ser_rsp_t     ser_rsp;

    logic [ngmr_pkg::SIZE_W-1:0] m_eff;
    logic [ngmr_pkg::POLY_W-1:0] p_in;
    logic                        slot_free;
    logic                        is_last;

    ngmr_clmul u_clmul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (mul_cmd),
        .multiplicand (pw_reg),
        .multiplier   (p_reg),
        .rsp          (mul_rsp),
        .product      (product)
    );

    ngmr_series u_series
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ser_cmd),
        .q     (pw_reg),
        .rsp   (ser_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ngmr_pkg::ST_IDLE;
            size_reg      <= ngmr_pkg::SIZE_W'(ngmr_pkg::MAX_SIZE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        e_reg         <= e_next;
        p_reg         <= p_next;
        pw_reg        <= pw_next;
        d_reg         <= d_next;
        k_reg         <= k_next;
        row_reg       <= row_next;
        chk_reg       <= chk_next;
        err_reg       <= err_next;
        out_index_reg <= out_index_next;
        out_bits_reg  <= out_bits_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign cfg.ready = 1'b1;
    assign size_next = (cfg.valid) ? cfg.matrix_size : size_reg;

    always_comb
    begin
        if (size_reg == '0)
            m_eff = ngmr_pkg::SIZE_W'(1);
        else if (size_reg > ngmr_pkg::SIZE_W'(ngmr_pkg::MAX_SIZE))
            m_eff = ngmr_pkg::SIZE_W'(ngmr_pkg::MAX_SIZE);
        else
            m_eff = size_reg;
    end

    // monic polynomial: low bits at or above the degree are dropped
    always_comb
    begin
        p_in = '0;
        for (int i = 0; i < ngmr_pkg::LOW_W; i++)
            p_in[i] = poly.poly_low_bits[i] & (i < int'(poly.degree));
        p_in[poly.degree] = 1'b1;
    end

    assign poly.ready = (state_reg == ngmr_pkg::ST_IDLE);
    assign slot_free  = !out_valid_reg || rows.ready;
    assign is_last    = err_reg || (row_reg == m_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        pw_next        = pw_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        chk_next       = chk_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !rows.ready;
        out_index_next = out_index_reg;
        out_bits_next  = out_bits_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        mul_cmd.start  = 1'b0;
        mul_cmd.count  = e_reg;
        ser_cmd.start  = 1'b0;
        ser_cmd.k      = k_reg;
        ser_cmd.m      = m_reg;
        ser_cmd.d      = d_reg;

        case (state_reg)
            ngmr_pkg::ST_IDLE:
            begin
                if (poly.valid)
                begin
                    m_next   = m_eff;
                    e_next   = poly.degree;
                    p_next   = p_in;
                    chk_next = ngmr_pkg::STEP_W'(poly.degree);
                    row_next = '0;
                    err_next = (poly.degree == '0);
                    state_next = (poly.degree == '0) ? ngmr_pkg::ST_EMIT
                                                     : ngmr_pkg::ST_CHECK;
                end
            end
            ngmr_pkg::ST_CHECK:
            begin
                // smallest multiple of e reaching m is the top power degree
                if (chk_reg < ngmr_pkg::STEP_W'(m_reg))
                    chk_next = chk_reg + ngmr_pkg::STEP_W'(e_reg);
                else if (chk_reg > ngmr_pkg::STEP_W'(ngmr_pkg::POWER_LIMIT))
                begin
                    err_next   = 1'b1;
                    state_next = ngmr_pkg::ST_EMIT;
                end
                else
                begin
                    pw_next       = p_reg;
                    d_next        = e_reg;
                    k_next        = '0;
                    ser_cmd.start = 1'b1;
                    state_next    = ngmr_pkg::ST_SERIES;
                end
            end
            ngmr_pkg::ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    pw_next       = product;
                    ser_cmd.start = 1'b1;
                    state_next    = ngmr_pkg::ST_SERIES;
                end
            end
            ngmr_pkg::ST_SERIES:
            begin
                if (ser_rsp.done)
                    state_next = ngmr_pkg::ST_EMIT;
            end
            ngmr_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = err_reg ? '0 : row_reg;
                    out_bits_next  = err_reg ? '0 : ser_rsp.bits;
                    out_last_next  = is_last;
                    out_err_next   = err_reg;
                    if (is_last)
                        state_next = ngmr_pkg::ST_IDLE;
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        if (k_reg + 1'b1 == e_reg)
                        begin
                            k_next        = '0;
                            d_next        = d_reg + e_reg;
                            mul_cmd.start = 1'b1;
                            state_next    = ngmr_pkg::ST_MUL;
                        end
                        else
                        begin
                            k_next        = k_reg + 1'b1;
                            ser_cmd.start = 1'b1;
                            state_next    = ngmr_pkg::ST_SERIES;
                        end
                    end
                end
            end
            default:
                state_next = ngmr_pkg::ST_IDLE;
        endcase
    end

    assign rows.valid        = out_valid_reg;
    assign rows.row_index    = out_index_reg;
    assign rows.row_bits     = out_bits_reg;
    assign rows.last_row     = out_last_reg;
    assign rows.degree_error = out_err_reg;

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ngmr_pkg::ST_MUL))
        else $error("multiply finished outside its state");
    a_ser_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ser_rsp.done |-> (state_reg == ngmr_pkg::ST_SERIES))
        else $error("series finished outside its state");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ngmr_pkg::ST_SERIES) |-> (k_reg < e_reg))
        else $error("row offset beyond degree");
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (rows.valid && rows.degree_error) |-> (rows.row_bits == '0 && rows.last_row))
        else $error("malformed error beat");

endmodule

>>> rtl/ngmr_clmul.sv
// Bit-serial carry-less multiplier, one multiplier bit per cycle.
// Depends on ngmr_pkg.
module ngmr_clmul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ngmr_pkg::ngmr_mul_cmd_t       cmd,
    input  logic [ngmr_pkg::POLY_W-1:0]   multiplicand,
    input  logic [ngmr_pkg::POLY_W-1:0]   multiplier,
    output ngmr_pkg::ngmr_mul_rsp_t       rsp,
    output logic [ngmr_pkg::POLY_W-1:0]   product
);

    logic [ngmr_pkg::POLY_W-1:0] a_reg, a_next;
    logic [ngmr_pkg::POLY_W-1:0] b_reg, b_next;
    logic [ngmr_pkg::POLY_W-1:0] acc_reg, acc_next;
    logic [ngmr_pkg::DEG_W-1:0]  n_reg, n_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        n_reg   <= n_next;
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            a_next    = multiplicand;
            b_next    = multiplier;
            acc_next  = '0;
            n_next    = cmd.count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg ^ a_reg;
            a_next = {a_reg[ngmr_pkg::POLY_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[ngmr_pkg::POLY_W-1:1]};
            if (n_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                n_next = n_reg - 1'b1;
        end
    end

    assign rsp.done = done_reg;
    assign product  = acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("multiply started while busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiply done while still stepping");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("multiply done without a run");

endmodule

>>> rtl/ngmr_series.sv
// Serial long division giving the Laurent digits of 1/q, one digit per cycle,
// and the capture of one m-digit row window. Depends on ngmr_pkg.
module ngmr_series
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ngmr_pkg::ngmr_ser_cmd_t     cmd,
    input  logic [ngmr_pkg::POLY_W-1:0] q,
    output ngmr_pkg::ngmr_ser_rsp_t     rsp
);

    logic [ngmr_pkg::POLY_W-1:0] r_reg, r_next;
    logic [ngmr_pkg::STEP_W-1:0] t_reg, t_next;
    logic [ngmr_pkg::ROW_W-1:0]  bits_reg, bits_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [ngmr_pkg::POLY_W-1:0] shifted;
    logic                        digit;
    logic [ngmr_pkg::STEP_W-1:0] k_ext;
    logic [ngmr_pkg::STEP_W-1:0] stop;
    logic [ngmr_pkg::STEP_W-1:0] col_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        t_reg    <= t_next;
        bits_reg <= bits_next;
    end

    // remainder holds x^t mod q; the digit of x^-(t+1) pops out at bit d
    always_comb
    begin
        shifted   = {r_reg[ngmr_pkg::POLY_W-2:0], 1'b0};
        digit     = shifted[cmd.d];
        k_ext     = {1'b0, cmd.k};
        stop      = k_ext + ngmr_pkg::STEP_W'(cmd.m);
        col_full  = t_reg - k_ext;
        r_next    = r_reg;
        t_next    = t_reg;
        bits_next = bits_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            r_next    = ngmr_pkg::POLY_W'(1);
            t_next    = '0;
            bits_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next = digit ? (shifted ^ q) : shifted;
            t_next = t_reg + 1'b1;
            if (t_reg >= k_ext)
                bits_next[col_full[ngmr_pkg::SIZE_W-1:0]] = digit;
            if (t_next == stop)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.bits = bits_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("series started while busy");
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (t_reg < stop))
        else $error("series ran past its row window");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("series done without a run");

endmodule

>>> tb/tb_niederreiter_gf2_matrix_rows.sv
// Self-checking bench for the base-2 Niederreiter generating-matrix row generator.
// Drives polynomial beats and matrix size writes, predicts every row beat, checks them.
// Depends on ngmr_pkg, ngmr_if and niederreiter_gf2_matrix_rows.
module tb_niederreiter_gf2_matrix_rows;
    import ngmr_pkg::*;

    localparam int SERIES_LEN = POWER_LIMIT + MAX_SIZE + 2;
    localparam int RUN_LIMIT  = 3000000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [SIZE_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic              last_row;
        logic              degree_error;
    } row_beat_t;

    typedef enum logic [1:0] {
        JOB_POLY,
        JOB_SIZE,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t         kind;
        logic [LOW_W-1:0]  low;
        logic [DEG_W-1:0]  deg;
        logic [SIZE_W-1:0] size;
        int                gap;
    } job_t;

    logic clk;
    logic rst_n;

    ngmr_cfg_if cfg_ch ();
    ngmr_in_if  poly_ch ();
    ngmr_out_if rows_ch ();

    niederreiter_gf2_matrix_rows u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .poly  (poly_ch),
        .rows  (rows_ch)
    );

    job_t      pending_jobs [$];
    row_beat_t expected_rows [$];

    logic [SIZE_W-1:0] size_model;
    int mismatches;
    int polys_sent;
    int size_writes;
    int rows_checked;
    int error_beats;
    int cycle_count;
    bit rows_eager;
    bit gap_burst;

    function automatic logic [63:0] gf2_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] acc;
        acc = '0;
        for (int n = 0; n < 64; n++)
            if (b[n])
                acc ^= a << n;
        return acc;
    endfunction

    // Rows of the generating matrix: powers of p, then the Laurent expansion of 1/p^(Q+1)
    task automatic predict_rows(input logic [SIZE_W-1:0] size_reg, input logic [LOW_W-1:0] low,
                                input logic [DEG_W-1:0] deg);
        int          m;
        int          e;
        int          qq;
        int          k;
        int          d;
        int          top;
        logic [63:0] p;
        logic [63:0] pw;
        bit          coef [0:SERIES_LEN-1];
        bit          acc_bit;
        row_beat_t   r;
        m = (size_reg == 0) ? 1 : ((size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg));
        e = int'(deg);
        if (e == 0 || ((m - 1) / e + 1) * e > POWER_LIMIT)
        begin
            r.row_index    = '0;
            r.row_bits     = '0;
            r.last_row     = 1'b1;
            r.degree_error = 1'b1;
            expected_rows = {expected_rows, r};
        end
        else
        begin
            p   = (64'd1 << e) | ({1'b0, low} & ((64'd1 << e) - 64'd1));
            top = e - 1 + m;
            for (int i = 0; i < m; i++)
            begin
                qq = i / e;
                k  = i % e;
                d  = (qq + 1) * e;
                pw = p;
                for (int rr = 1; rr <= qq; rr++)
                    pw = gf2_mul(pw, p);
                foreach (coef[n])
                    coef[n] = 1'b0;
                if (d <= top)
                    coef[d] = 1'b1;
                for (int n = d + 1; n <= top; n++)
                begin
                    acc_bit = 1'b0;
                    for (int j = 0; j < d && j < 64; j++)
                        if (pw[j])
                            acc_bit ^= coef[n - d + j];
                    coef[n] = acc_bit;
                end
                r.row_index = i[SIZE_W-1:0];
                r.row_bits  = '0;
                for (int l = 0; l < m; l++)
                    r.row_bits[l] = coef[k + l + 1];
                r.last_row     = (i == m - 1);
                r.degree_error = 1'b0;
                expected_rows = {expected_rows, r};
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH beat %0d: %s", rows_checked, msg);
    endtask

    task automatic add_poly(input logic [LOW_W-1:0] low, input logic [DEG_W-1:0] deg);
        job_t j;
        if ($urandom_range(0, 9) == 0)
            gap_burst = !gap_burst;
        j.kind = JOB_POLY;
        j.low  = low;
        j.deg  = deg;
        j.size = '0;
        j.gap  = gap_burst ? 0 : $urandom_range(0, 4);
        pending_jobs = {pending_jobs, j};
    endtask

    task automatic add_job(input job_kind_t kind, input logic [SIZE_W-1:0] size);
        job_t j;
        j.kind = kind;
        j.low  = '0;
        j.deg  = '0;
        j.size = size;
        j.gap  = 0;
        pending_jobs = {pending_jobs, j};
    endtask

    function automatic logic [LOW_W-1:0] rand_low();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = w & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return w[LOW_W-1:0];
    endfunction

    function automatic logic [DEG_W-1:0] rand_degree();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick < 6)
            return DEG_W'($urandom_range(1, 8));
        else
            return DEG_W'($urandom_range(1, 63));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Polynomial and size-write driver
    always @(posedge clk or negedge rst_n)
    begin
        bit nv_poly;
        bit nv_cfg;
        int hold;
        if (!rst_n)
        begin
            poly_ch.valid <= 1'b0;
            cfg_ch.valid  <= 1'b0;
            size_model = SIZE_W'(MAX_SIZE);
            hold = 0;
        end
        else
        begin
            nv_poly = poly_ch.valid;
            nv_cfg  = cfg_ch.valid;
            if (poly_ch.valid && poly_ch.ready)
            begin
                predict_rows(size_model, poly_ch.poly_low_bits, poly_ch.degree);
                polys_sent++;
                nv_poly = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                size_model = cfg_ch.matrix_size;
                size_writes++;
                nv_cfg = 1'b0;
            end
            if (!nv_poly && !nv_cfg && pending_jobs.size() != 0)
            begin
                if (hold < pending_jobs[0].gap)
                    hold++;
                else
                begin
                    case (pending_jobs[0].kind)
                        JOB_POLY:
                        begin
                            poly_ch.poly_low_bits <= pending_jobs[0].low;
                            poly_ch.degree        <= pending_jobs[0].deg;
                            nv_poly = 1'b1;
                            hold = 0;
                            void'(pending_jobs.pop_front());
                        end
                        JOB_SIZE:
                        begin
                            if (expected_rows.size() == 0)
                            begin
                                cfg_ch.matrix_size <= pending_jobs[0].size;
                                nv_cfg = 1'b1;
                                void'(pending_jobs.pop_front());
                            end
                        end
                        default:
                        begin
                            if (expected_rows.size() == 0)
                                void'(pending_jobs.pop_front());
                        end
                    endcase
                end
            end
            poly_ch.valid <= nv_poly;
            cfg_ch.valid  <= nv_cfg;
        end
    end

    // Row beat monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        bit        nr;
        int        stall;
        row_beat_t want;
        if (!rst_n)
        begin
            rows_ch.ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            nr = rows_ch.ready;
            if (rows_ch.valid && rows_ch.ready)
            begin
                if (expected_rows.size() == 0)
                    report_mismatch($sformatf("unexpected beat, row_index %0d row_bits 0x%0h",
                                              rows_ch.row_index, rows_ch.row_bits));
                else
                begin
                    want = expected_rows.pop_front();
                    if (rows_ch.row_index !== want.row_index)
                        report_mismatch($sformatf("row_index got %0d want %0d",
                                                  rows_ch.row_index, want.row_index));
                    if (rows_ch.row_bits !== want.row_bits)
                        report_mismatch($sformatf("row %0d row_bits got 0x%08h want 0x%08h",
                                                  want.row_index, rows_ch.row_bits,
                                                  want.row_bits));
                    if (rows_ch.last_row !== want.last_row)
                        report_mismatch($sformatf("row %0d last_row got %b want %b",
                                                  want.row_index, rows_ch.last_row,
                                                  want.last_row));
                    if (rows_ch.degree_error !== want.degree_error)
                        report_mismatch($sformatf("row %0d degree_error got %b want %b",
                                                  want.row_index, rows_ch.degree_error,
                                                  want.degree_error));
                end
                if (rows_ch.degree_error === 1'b1)
                    error_beats++;
                rows_checked++;
                if ($urandom_range(0, 15) == 0)
                    rows_eager = !rows_eager;
                stall = rows_eager ? 0 : $urandom_range(0, 4);
                nr = (stall == 0);
            end
            else if (!rows_ch.ready)
            begin
                if (stall > 1)
                    stall--;
                else
                begin
                    stall = 0;
                    nr = 1'b1;
                end
            end
            rows_ch.ready <= nr;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_niederreiter_gf2_matrix_rows NOT OK");
        $finish;
    end

    initial
    begin
        logic [SIZE_W-1:0] phase_size [5];
        rst_n                 = 1'b0;
        poly_ch.valid         = 1'b0;
        poly_ch.poly_low_bits = '0;
        poly_ch.degree        = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.matrix_size    = '0;
        rows_ch.ready         = 1'b0;
        mismatches   = 0;
        polys_sent   = 0;
        size_writes  = 0;
        rows_checked = 0;
        error_beats  = 0;
        rows_eager   = 1'b0;
        gap_burst    = 1'b0;

        // Directed: size 30 from reset
        add_poly('0, 6'd1);
        add_poly('1, 6'd1);
        add_poly(LOW_W'(3), 6'd2);
        add_poly('0, 6'd0);
        add_poly('1, 6'd0);
        add_poly('1, 6'd63);
        add_poly('0, 6'd63);
        add_poly(LOW_W'({32{2'b10}}), 6'd62);
        add_poly(LOW_W'({32{2'b01}}), 6'd32);
        add_poly(rand_low(), 6'd31);
        add_poly(rand_low(), 6'd30);
        add_poly(rand_low(), 6'd29);
        add_poly(rand_low(), 6'd15);
        add_poly(rand_low(), 6'd16);
        add_poly(rand_low(), 6'd7);
        // size zero behaves as one
        add_job(JOB_SIZE, 5'd0);
        add_poly(LOW_W'(1), 6'd1);
        add_poly(rand_low(), 6'd63);
        add_poly(rand_low(), 6'd0);
        // size above the maximum saturates
        add_job(JOB_SIZE, 5'd31);
        add_poly(rand_low(), 6'd5);
        add_poly('0, 6'd1);
        add_job(JOB_SIZE, 5'd1);
        add_poly(rand_low(), 6'd4);
        add_job(JOB_SIZE, 5'd2);
        add_poly(LOW_W'(1), 6'd1);
        add_poly(rand_low(), 6'd2);

        // Random phases
        phase_size[0] = SIZE_W'($urandom_range(3, 12));
        phase_size[1] = SIZE_W'(MAX_SIZE);
        phase_size[2] = SIZE_W'($urandom_range(0, 31));
        phase_size[3] = 5'd31;
        phase_size[4] = SIZE_W'($urandom_range(1, 6));
        for (int ph = 0; ph < 5; ph++)
        begin
            add_job(JOB_SIZE, phase_size[ph]);
            for (int n = 0; n < 16; n++)
            begin
                if (ph == 1 && n == 10)
                    add_job(JOB_DRAIN, '0);
                add_poly(rand_low(), rand_degree());
            end
        end

        repeat (11) @(posedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (pending_jobs.size() != 0 || poly_ch.valid || cfg_ch.valid ||
               expected_rows.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d polynomials and %0d size writes; %0d row beats checked, %0d errors.",
                 polys_sent, size_writes, rows_checked, error_beats);
        $display("Mismatches: %0d, cycles: %0d", mismatches, cycle_count);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("tb_niederreiter_gf2_matrix_rows OK");
        else
            $display("tb_niederreiter_gf2_matrix_rows NOT OK");
        $finish;
    end

endmodule
